// ===== sv/lrfp_pkg.sv =====
`default_nettype none

package lrfp_pkg;

  localparam int MAX_RESPONSE_BYTES = 128;
  localparam int DESCRIPTOR_BYTES   = 7;

  localparam logic [7:0] SYNC_0     = 8'hA5;
  localparam logic [7:0] SYNC_1     = 8'h5A;
  localparam logic [7:0] CODE_INFO  = 8'h04;
  localparam logic [7:0] CODE_HEALTH = 8'h06;
  localparam logic [7:0] CODE_RATE  = 8'h15;
  localparam logic [7:0] CODE_CONF  = 8'h20;
  localparam logic [7:0] CODE_SCAN  = 8'h81;
  localparam logic [7:0] CODE_EXPRESS = 8'h85;

  localparam logic [1:0] DMODE_SINGLE = 2'd0;
  localparam logic [1:0] DMODE_MULTI  = 2'd1;

  localparam logic [2:0] CFG_INFO_LEN     = 3'd0;
  localparam logic [2:0] CFG_HEALTH_LEN   = 3'd1;
  localparam logic [2:0] CFG_RATE_LEN     = 3'd2;
  localparam logic [2:0] CFG_SCAN_LEN     = 3'd3;
  localparam logic [2:0] CFG_DENSE_LEN    = 3'd4;
  localparam logic [2:0] CFG_MEAS_COUNT   = 3'd5;
  localparam logic [2:0] CFG_BUFFER_MODE  = 3'd6;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [1:0] {
    MODE_DESC   = 2'd0,
    MODE_SINGLE = 2'd1,
    MODE_MULTI  = 2'd2,
    MODE_ERROR  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    KIND_UNKNOWN = 3'd0,
    KIND_INFO    = 3'd1,
    KIND_HEALTH  = 3'd2,
    KIND_RATE    = 3'd3,
    KIND_CONF    = 3'd4,
    KIND_SCAN    = 3'd5,
    KIND_EXPRESS = 3'd6
  } kind_t;

  typedef struct packed {
    logic [7:0]  info_len;
    logic [7:0]  health_len;
    logic [7:0]  rate_len;
    logic [7:0]  scan_len;
    logic [7:0]  dense_len;
    logic [15:0] measurement_count;
    logic        buffer_mode;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [6:0]  byte_index;
    logic        payload_valid;
    logic        frame_done;
    logic        frame_ok;
    kind_t       resp_kind;
    logic        delivered;
    logic        error_latched;
    logic [15:0] remaining;
    logic [31:0] conf_type_word;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/lrfp_in_if.sv =====
`default_nettype none

interface lrfp_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink (input valid, input action, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== sv/lrfp_out_if.sv =====
`default_nettype none

interface lrfp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_out;
  logic [6:0]  byte_index;
  logic        payload_valid;
  logic        frame_done;
  logic        frame_ok;
  logic [2:0]  resp_kind;
  logic        delivered;
  logic        error_latched;
  logic [15:0] remaining;
  logic [31:0] conf_type_word;

  modport source (
    output valid, output byte_out, output byte_index, output payload_valid,
    output frame_done, output frame_ok, output resp_kind, output delivered,
    output error_latched, output remaining, output conf_type_word, input ready
  );
  modport sink (
    input valid, input byte_out, input byte_index, input payload_valid,
    input frame_done, input frame_ok, input resp_kind, input delivered,
    input error_latched, input remaining, input conf_type_word, output ready
  );
endinterface

`default_nettype wire

// ===== sv/lrfp_cfg_regs.sv =====
`default_nettype none

module lrfp_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [lrfp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [lrfp_pkg::CFG_DATA_W-1:0]  cfg_data,
  output lrfp_pkg::cfg_t                        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.info_len          <= 8'd20;
      cfg.health_len        <= 8'd3;
      cfg.rate_len          <= 8'd4;
      cfg.scan_len          <= 8'd5;
      cfg.dense_len         <= 8'd84;
      cfg.measurement_count <= 16'd0;
      cfg.buffer_mode       <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        lrfp_pkg::CFG_INFO_LEN:    cfg.info_len          <= cfg_data[7:0];
        lrfp_pkg::CFG_HEALTH_LEN:  cfg.health_len        <= cfg_data[7:0];
        lrfp_pkg::CFG_RATE_LEN:    cfg.rate_len          <= cfg_data[7:0];
        lrfp_pkg::CFG_SCAN_LEN:    cfg.scan_len          <= cfg_data[7:0];
        lrfp_pkg::CFG_DENSE_LEN:   cfg.dense_len         <= cfg_data[7:0];
        lrfp_pkg::CFG_MEAS_COUNT:  cfg.measurement_count <= cfg_data[15:0];
        lrfp_pkg::CFG_BUFFER_MODE: cfg.buffer_mode       <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/lrfp_parser.sv =====
`default_nettype none

module lrfp_parser (
  input  wire logic           clk,
  input  wire logic           rst,
  lrfp_in_if.sink             in_ch,
  input  wire lrfp_pkg::cfg_t cfg,
  input  wire logic           res_space,
  output logic                res_load,
  output lrfp_pkg::result_t   res
);

  logic       s1_valid;
  logic       s1_action;
  logic [7:0] s1_byte;
  logic       in_take;

  lrfp_pkg::mode_t mode, mode_next;
  lrfp_pkg::kind_t kind, kind_next;
  logic [2:0]  dcount, dcount_next;
  logic [7:0]  sync0, sync0_next;
  logic [7:0]  sync1, sync1_next;
  logic [7:0]  len_byte, len_byte_next;
  logic [1:0]  dmode, dmode_next;
  logic [7:0]  payload_length, payload_length_next;
  logic [7:0]  pcount, pcount_next;
  logic [15:0] scan_countdown, scan_countdown_next;
  logic [31:0] config_word, config_word_next;
  logic        check_bit, check_bit_next;

  function automatic lrfp_pkg::kind_t kind_of(input logic [7:0] code);
    case (code)
      lrfp_pkg::CODE_INFO:    kind_of = lrfp_pkg::KIND_INFO;
      lrfp_pkg::CODE_HEALTH:  kind_of = lrfp_pkg::KIND_HEALTH;
      lrfp_pkg::CODE_RATE:    kind_of = lrfp_pkg::KIND_RATE;
      lrfp_pkg::CODE_CONF:    kind_of = lrfp_pkg::KIND_CONF;
      lrfp_pkg::CODE_SCAN:    kind_of = lrfp_pkg::KIND_SCAN;
      lrfp_pkg::CODE_EXPRESS: kind_of = lrfp_pkg::KIND_EXPRESS;
      default:                kind_of = lrfp_pkg::KIND_UNKNOWN;
    endcase
  endfunction

  assign res_load    = s1_valid && res_space;
  assign in_ch.ready = !s1_valid || res_space;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (res_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_action <= in_ch.action;
      s1_byte   <= in_ch.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= lrfp_pkg::MODE_DESC;
      kind           <= lrfp_pkg::KIND_UNKNOWN;
      dcount         <= 3'd0;
      payload_length <= 8'd0;
      pcount         <= 8'd0;
      scan_countdown <= 16'd0;
      config_word    <= 32'd0;
      check_bit      <= 1'b0;
    end else if (res_load) begin
      mode           <= mode_next;
      kind           <= kind_next;
      dcount         <= dcount_next;
      payload_length <= payload_length_next;
      pcount         <= pcount_next;
      scan_countdown <= scan_countdown_next;
      config_word    <= config_word_next;
      check_bit      <= check_bit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      sync0    <= sync0_next;
      sync1    <= sync1_next;
      len_byte <= len_byte_next;
      dmode    <= dmode_next;
    end
  end

  always_comb begin
    logic [7:0]  p;
    logic [7:0]  p1;
    logic [31:0] word;
    logic        done;
    logic        ok;
    logic        deliv;

    mode_next           = mode;
    kind_next           = kind;
    dcount_next         = dcount;
    sync0_next          = sync0;
    sync1_next          = sync1;
    len_byte_next       = len_byte;
    dmode_next          = dmode;
    payload_length_next = payload_length;
    pcount_next         = pcount;
    scan_countdown_next = scan_countdown;
    config_word_next    = config_word;
    check_bit_next      = check_bit;
    res                 = '0;
    p                   = pcount;
    p1                  = 8'(pcount + 8'd1);
    word                = config_word;
    done                = 1'b0;
    ok                  = 1'b0;
    deliv               = 1'b0;

    if (s1_action) begin
      mode_next           = lrfp_pkg::MODE_DESC;
      kind_next           = lrfp_pkg::KIND_UNKNOWN;
      dcount_next         = 3'd0;
      payload_length_next = 8'd0;
      pcount_next         = 8'd0;
      config_word_next    = 32'd0;
      check_bit_next      = 1'b0;
      scan_countdown_next = cfg.measurement_count;
    end else begin
      case (mode)
        lrfp_pkg::MODE_DESC: begin
          case (dcount)
            3'd0: sync0_next = s1_byte;
            3'd1: sync1_next = s1_byte;
            3'd2: len_byte_next = s1_byte;
            3'd5: dmode_next = s1_byte[7:6];
            default: ;
          endcase
          if (dcount == 3'(lrfp_pkg::DESCRIPTOR_BYTES - 1)) begin
            dcount_next         = 3'd0;
            payload_length_next = len_byte;
            kind_next           = kind_of(s1_byte);
            pcount_next         = 8'd0;
            config_word_next    = 32'd0;
            check_bit_next      = 1'b0;
            if (sync0 != lrfp_pkg::SYNC_0 || sync1 != lrfp_pkg::SYNC_1) begin
              mode_next = lrfp_pkg::MODE_ERROR;
            end else if (len_byte == 8'd0 ||
                         len_byte > 8'(lrfp_pkg::MAX_RESPONSE_BYTES)) begin
              mode_next = lrfp_pkg::MODE_ERROR;
            end else if (dmode == lrfp_pkg::DMODE_SINGLE) begin
              mode_next = lrfp_pkg::MODE_SINGLE;
            end else if (dmode == lrfp_pkg::DMODE_MULTI) begin
              mode_next = lrfp_pkg::MODE_MULTI;
            end else begin
              mode_next = lrfp_pkg::MODE_ERROR;
            end
          end else begin
            dcount_next = 3'(dcount + 3'd1);
          end
        end
        lrfp_pkg::MODE_SINGLE, lrfp_pkg::MODE_MULTI: begin
          if (p == 8'd0) begin
            word           = 32'd0;
            check_bit_next = 1'b0;
          end
          case (p)
            8'd0: word[7:0]   = s1_byte;
            8'd1: word[15:8]  = s1_byte;
            8'd2: word[23:16] = s1_byte;
            8'd3: word[31:24] = s1_byte;
            default: ;
          endcase
          if (p == 8'd1) begin
            check_bit_next = s1_byte[0];
          end
          config_word_next = word;
          res.payload_valid = 1'b1;
          res.byte_out      = s1_byte;
          res.byte_index    = p[6:0];
          pcount_next       = p1;
          if (p1 >= payload_length) begin
            done = 1'b1;
            case (kind)
              lrfp_pkg::KIND_INFO:    ok = (p1 == cfg.info_len);
              lrfp_pkg::KIND_HEALTH:  ok = (p1 == cfg.health_len);
              lrfp_pkg::KIND_RATE:    ok = (p1 == cfg.rate_len);
              lrfp_pkg::KIND_CONF:    ok = 1'b1;
              lrfp_pkg::KIND_SCAN:    ok = (p1 == cfg.scan_len) && check_bit_next;
              lrfp_pkg::KIND_EXPRESS: ok = (p1 == cfg.dense_len);
              default:                ok = 1'b0;
            endcase
            if (ok) begin
              if ((kind == lrfp_pkg::KIND_SCAN || kind == lrfp_pkg::KIND_EXPRESS) &&
                  cfg.buffer_mode) begin
                if (scan_countdown != 16'd0) begin
                  scan_countdown_next = 16'(scan_countdown - 16'd1);
                  deliv               = 1'b1;
                end
              end else begin
                deliv = 1'b1;
              end
              if (kind == lrfp_pkg::KIND_CONF) begin
                res.conf_type_word = word;
              end
              if (mode == lrfp_pkg::MODE_SINGLE) begin
                mode_next = lrfp_pkg::MODE_DESC;
              end
            end else begin
              mode_next = lrfp_pkg::MODE_ERROR;
            end
            pcount_next = 8'd0;
          end
        end
        default: ;
      endcase
    end

    res.frame_done    = done;
    res.frame_ok      = ok;
    res.delivered     = deliv;
    res.resp_kind     = kind_next;
    res.error_latched = (mode_next == lrfp_pkg::MODE_ERROR);
    res.remaining     = scan_countdown_next;
  end

  a_done_is_payload: assert property (@(posedge clk) disable iff (rst)
    res_load && res.frame_done |-> res.payload_valid)
    else $error("frame end on a non-payload byte");

  a_deliver_needs_ok: assert property (@(posedge clk) disable iff (rst)
    res_load && res.delivered |-> res.frame_ok && res.frame_done)
    else $error("frame delivered without passing its checks");

  a_restart_to_desc: assert property (@(posedge clk) disable iff (rst)
    res_load && s1_action |=> mode == lrfp_pkg::MODE_DESC && pcount == 8'd0)
    else $error("restart did not return to descriptor collection");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    mode == lrfp_pkg::MODE_ERROR && !(res_load && s1_action) |=>
      mode == lrfp_pkg::MODE_ERROR)
    else $error("error state left without restart");

  a_countdown_step: assert property (@(posedge clk) disable iff (rst)
    res_load && !s1_action |=> scan_countdown == $past(scan_countdown) ||
      scan_countdown == 16'($past(scan_countdown) - 16'd1))
    else $error("countdown moved by more than one");

endmodule

`default_nettype wire

// ===== sv/lrfp_out_stage.sv =====
`default_nettype none

module lrfp_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              res_load,
  input  wire lrfp_pkg::result_t res,
  output logic                   res_space,
  lrfp_out_if.source             out_ch
);

  lrfp_pkg::result_t held;
  logic              held_valid;

  assign res_space = !held_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (res_load) begin
      held_valid <= 1'b1;
    end else if (out_ch.ready) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      held <= res;
    end
  end

  assign out_ch.valid          = held_valid;
  assign out_ch.byte_out       = held.byte_out;
  assign out_ch.byte_index     = held.byte_index;
  assign out_ch.payload_valid  = held.payload_valid;
  assign out_ch.frame_done     = held.frame_done;
  assign out_ch.frame_ok       = held.frame_ok;
  assign out_ch.resp_kind      = held.resp_kind;
  assign out_ch.delivered      = held.delivered;
  assign out_ch.error_latched  = held.error_latched;
  assign out_ch.remaining      = held.remaining;
  assign out_ch.conf_type_word = held.conf_type_word;

endmodule

`default_nettype wire

// ===== sv/lidar_response_frame_parser.sv =====
// Path: input register, single-pass parse logic, output register. Throughput:
// one received byte per cycle while the output register has space or is draining,
// so input ready stays high while results drain.
// Reset (rst, synchronous): parser returns to descriptor collection, counts,
// kind, countdown and type word cleared, configuration registers to defaults.
`default_nettype none

module lidar_response_frame_parser (
  input  wire logic                             clk,
  input  wire logic                             rst,
  lrfp_in_if.sink                               in_ch,
  lrfp_out_if.source                            out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [lrfp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [lrfp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  lrfp_pkg::cfg_t    cfg;
  lrfp_pkg::result_t res;
  logic              res_load;
  logic              res_space;

  lrfp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lrfp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .res_space (res_space),
    .res_load  (res_load),
    .res       (res)
  );

  lrfp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_load  (res_load),
    .res       (res),
    .res_space (res_space),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int          CLOCK_LIMIT   = 200000;
  localparam int          RANDOM_BYTES  = 650;
  localparam logic [15:0] OPENING_COUNT = 16'd3;

  typedef struct packed {
    logic            act;
    logic [7:0]      rx;
    logic            typed;
    lrfp_pkg::kind_t kind;
    logic            err;
  } opening_row_t;

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             cfg_we;
  logic [lrfp_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [lrfp_pkg::CFG_DATA_W-1:0]  cfg_data;

  lrfp_in_if  in_ch ();
  lrfp_out_if out_ch ();

  lidar_response_frame_parser u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lrfp_pkg::cfg_t  regs;
  lrfp_pkg::mode_t pmode;
  logic [7:0]      desc_bytes [lrfp_pkg::DESCRIPTOR_BYTES];
  int              desc_count;
  logic [7:0]      frame_len;
  lrfp_pkg::kind_t frame_kind;
  logic [7:0]      byte_count;
  logic [15:0]     scan_left;
  logic [31:0]     type_word;
  logic            scan_check;

  lrfp_pkg::result_t pending_results [$];
  int      mismatches = 0;
  int      bytes_sent = 0;
  int      cycles     = 0;
  bit      calm       = 1'b0;
  bit      want_hold  = 1'b0;

  opening_row_t opening_rows [26] = '{
    '{1'b1, 8'hFF, 1'b1, lrfp_pkg::KIND_UNKNOWN, 1'b0},
    '{1'b0, 8'hA5, 1'b0, lrfp_pkg::KIND_UNKNOWN, 1'b0},
    '{1'b0, 8'h5A, 1'b0, lrfp_pkg::KIND_UNKNOWN, 1'b0},
    '{1'b0, 8'h01, 1'b0, lrfp_pkg::KIND_UNKNOWN, 1'b0},
    '{1'b0, 8'h00, 1'b0, lrfp_pkg::KIND_UNKNOWN, 1'b0},
    '{1'b0, 8'h00, 1'b0, lrfp_pkg::KIND_UNKNOWN, 1'b0},
    '{1'b0, 8'h00, 1'b0, lrfp_pkg::KIND_UNKNOWN, 1'b0},
    '{1'b0, 8'h20, 1'b0, lrfp_pkg::KIND_UNKNOWN, 1'b0},
    '{1'b0, 8'hFF, 1'b0, lrfp_pkg::KIND_UNKNOWN, 1'b0},
    '{1'b0, 8'hA5, 1'b0, lrfp_pkg::KIND_UNKNOWN, 1'b0},
    '{1'b0, 8'h5A, 1'b0, lrfp_pkg::KIND_UNKNOWN, 1'b0},
    '{1'b0, 8'h00, 1'b0, lrfp_pkg::KIND_UNKNOWN, 1'b0},
    '{1'b0, 8'hFF, 1'b0, lrfp_pkg::KIND_UNKNOWN, 1'b0},
    '{1'b0, 8'hFF, 1'b0, lrfp_pkg::KIND_UNKNOWN, 1'b0},
    '{1'b0, 8'h3F, 1'b0, lrfp_pkg::KIND_UNKNOWN, 1'b0},
    '{1'b0, 8'h81, 1'b1, lrfp_pkg::KIND_SCAN,    1'b1},
    '{1'b0, 8'h00, 1'b0, lrfp_pkg::KIND_UNKNOWN, 1'b0},
    '{1'b1, 8'h00, 1'b1, lrfp_pkg::KIND_UNKNOWN, 1'b0},
    '{1'b0, 8'h00, 1'b0, lrfp_pkg::KIND_UNKNOWN, 1'b0},
    '{1'b0, 8'h5A, 1'b0, lrfp_pkg::KIND_UNKNOWN, 1'b0},
    '{1'b0, 8'h01, 1'b0, lrfp_pkg::KIND_UNKNOWN, 1'b0},
    '{1'b0, 8'h00, 1'b0, lrfp_pkg::KIND_UNKNOWN, 1'b0},
    '{1'b0, 8'h00, 1'b0, lrfp_pkg::KIND_UNKNOWN, 1'b0},
    '{1'b0, 8'h00, 1'b0, lrfp_pkg::KIND_UNKNOWN, 1'b0},
    '{1'b0, 8'h04, 1'b1, lrfp_pkg::KIND_INFO,    1'b1},
    '{1'b1, 8'hFF, 1'b1, lrfp_pkg::KIND_UNKNOWN, 1'b0}
  };

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic lrfp_pkg::result_t parse_byte(logic act, logic [7:0] b);
    lrfp_pkg::result_t r;
    logic [7:0] p;
    logic ok;
    r = '0;
    ok = 1'b0;
    if (act) begin
      pmode = lrfp_pkg::MODE_DESC;
      desc_count = 0;
      frame_len = '0;
      frame_kind = lrfp_pkg::KIND_UNKNOWN;
      byte_count = '0;
      type_word = '0;
      scan_check = 1'b0;
      scan_left = regs.measurement_count;
    end else if (pmode == lrfp_pkg::MODE_DESC) begin
      desc_bytes[desc_count] = b;
      if (desc_count == lrfp_pkg::DESCRIPTOR_BYTES - 1) begin
        desc_count = 0;
        frame_len = desc_bytes[2];
        case (desc_bytes[6])
          lrfp_pkg::CODE_INFO:    frame_kind = lrfp_pkg::KIND_INFO;
          lrfp_pkg::CODE_HEALTH:  frame_kind = lrfp_pkg::KIND_HEALTH;
          lrfp_pkg::CODE_RATE:    frame_kind = lrfp_pkg::KIND_RATE;
          lrfp_pkg::CODE_CONF:    frame_kind = lrfp_pkg::KIND_CONF;
          lrfp_pkg::CODE_SCAN:    frame_kind = lrfp_pkg::KIND_SCAN;
          lrfp_pkg::CODE_EXPRESS: frame_kind = lrfp_pkg::KIND_EXPRESS;
          default:                frame_kind = lrfp_pkg::KIND_UNKNOWN;
        endcase
        byte_count = '0;
        type_word = '0;
        scan_check = 1'b0;
        if (desc_bytes[0] != lrfp_pkg::SYNC_0 || desc_bytes[1] != lrfp_pkg::SYNC_1)
          pmode = lrfp_pkg::MODE_ERROR;
        else if (frame_len == 0 || frame_len > lrfp_pkg::MAX_RESPONSE_BYTES)
          pmode = lrfp_pkg::MODE_ERROR;
        else if (desc_bytes[5][7:6] == lrfp_pkg::DMODE_SINGLE)
          pmode = lrfp_pkg::MODE_SINGLE;
        else if (desc_bytes[5][7:6] == lrfp_pkg::DMODE_MULTI)
          pmode = lrfp_pkg::MODE_MULTI;
        else
          pmode = lrfp_pkg::MODE_ERROR;
      end else begin
        desc_count++;
      end
    end else if (pmode == lrfp_pkg::MODE_SINGLE || pmode == lrfp_pkg::MODE_MULTI) begin
      p = byte_count;
      if (p == 0) begin
        type_word = '0;
        scan_check = 1'b0;
      end
      r.payload_valid = 1'b1;
      r.byte_out = b;
      r.byte_index = p[6:0];
      if (p < 4) type_word |= 32'(b) << (8 * p);
      if (p == 1) scan_check = b[0];
      p = p + 8'd1;
      if (p >= frame_len) begin
        r.frame_done = 1'b1;
        case (frame_kind)
          lrfp_pkg::KIND_INFO:    ok = (p == regs.info_len);
          lrfp_pkg::KIND_HEALTH:  ok = (p == regs.health_len);
          lrfp_pkg::KIND_RATE:    ok = (p == regs.rate_len);
          lrfp_pkg::KIND_CONF:    ok = 1'b1;
          lrfp_pkg::KIND_SCAN:    ok = (p == regs.scan_len) && scan_check;
          lrfp_pkg::KIND_EXPRESS: ok = (p == regs.dense_len);
          default:                ok = 1'b0;
        endcase
        r.frame_ok = ok;
        if (ok) begin
          if ((frame_kind == lrfp_pkg::KIND_SCAN || frame_kind == lrfp_pkg::KIND_EXPRESS) &&
              regs.buffer_mode) begin
            if (scan_left != 0) begin
              scan_left--;
              r.delivered = 1'b1;
            end
          end else begin
            r.delivered = 1'b1;
          end
          if (frame_kind == lrfp_pkg::KIND_CONF) r.conf_type_word = type_word;
          if (pmode == lrfp_pkg::MODE_SINGLE) pmode = lrfp_pkg::MODE_DESC;
        end else begin
          pmode = lrfp_pkg::MODE_ERROR;
        end
        p = '0;
      end
      byte_count = p;
    end
    r.resp_kind = frame_kind;
    r.error_latched = (pmode == lrfp_pkg::MODE_ERROR);
    r.remaining = scan_left;
    return r;
  endfunction

  task automatic push_byte(logic act, logic [7:0] b, logic typed = 1'b0,
                           lrfp_pkg::kind_t kind = lrfp_pkg::KIND_UNKNOWN,
                           logic err = 1'b0);
    int gap;
    lrfp_pkg::result_t want;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    want = parse_byte(act, b);
    if (typed) begin
      want = '0;
      want.resp_kind = kind;
      want.error_latched = err;
      want.remaining = OPENING_COUNT;
    end
    pending_results.push_back(want);
    bytes_sent++;
  endtask

  task automatic put_reg(logic [lrfp_pkg::CFG_INDEX_W-1:0] idx,
                         logic [lrfp_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic load_regs(lrfp_pkg::cfg_t c);
    put_reg(lrfp_pkg::CFG_INFO_LEN, 16'(c.info_len));
    put_reg(lrfp_pkg::CFG_HEALTH_LEN, 16'(c.health_len));
    put_reg(lrfp_pkg::CFG_RATE_LEN, 16'(c.rate_len));
    put_reg(lrfp_pkg::CFG_SCAN_LEN, 16'(c.scan_len));
    put_reg(lrfp_pkg::CFG_DENSE_LEN, 16'(c.dense_len));
    put_reg(lrfp_pkg::CFG_MEAS_COUNT, c.measurement_count);
    put_reg(lrfp_pkg::CFG_BUFFER_MODE, 16'(c.buffer_mode));
    cfg_we <= 1'b0;
    regs = c;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one reply: optional restart and noise, descriptor, then one or more frames unless the descriptor fails
  task automatic send_response();
    logic [7:0] code;
    logic [7:0] req;
    logic [7:0] len;
    logic [7:0] b;
    logic [1:0] dmode;
    int pick;
    int frames;
    calm = ($urandom_range(0, 4) == 0);
    if (pmode != lrfp_pkg::MODE_DESC || $urandom_range(0, 3) == 0)
      push_byte(1'b1, 8'($urandom));
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 4)) push_byte(1'b0, 8'($urandom));
    case ($urandom_range(0, 7))
      0:       code = lrfp_pkg::CODE_INFO;
      1:       code = lrfp_pkg::CODE_HEALTH;
      2:       code = lrfp_pkg::CODE_RATE;
      3:       code = lrfp_pkg::CODE_CONF;
      4, 5:    code = lrfp_pkg::CODE_SCAN;
      6:       code = lrfp_pkg::CODE_EXPRESS;
      default: code = 8'($urandom);
    endcase
    case (code)
      lrfp_pkg::CODE_INFO:    req = regs.info_len;
      lrfp_pkg::CODE_HEALTH:  req = regs.health_len;
      lrfp_pkg::CODE_RATE:    req = regs.rate_len;
      lrfp_pkg::CODE_SCAN:    req = regs.scan_len;
      lrfp_pkg::CODE_EXPRESS: req = regs.dense_len;
      default:                req = 8'($urandom_range(1, 8));
    endcase
    pick = $urandom_range(0, 19);
    if (pick == 0)
      len = 8'd0;
    else if (pick == 1)
      len = 8'($urandom_range(129, 255));
    else if (pick == 2)
      len = 8'd128;
    else if (pick < 6 || req == 0 || (req > 24 && $urandom_range(0, 2) != 0))
      len = 8'($urandom_range(1, 8));
    else
      len = req;
    pick = $urandom_range(0, 15);
    if (pick == 0) dmode = 2'd2;
    else if (pick == 1) dmode = 2'd3;
    else if (pick < 7) dmode = lrfp_pkg::DMODE_MULTI;
    else dmode = lrfp_pkg::DMODE_SINGLE;
    pick = $urandom_range(0, 31);
    push_byte(1'b0, (pick == 0) ? 8'($urandom) : lrfp_pkg::SYNC_0);
    push_byte(1'b0, (pick == 1) ? 8'($urandom) : lrfp_pkg::SYNC_1);
    push_byte(1'b0, len);
    push_byte(1'b0, 8'($urandom));
    push_byte(1'b0, 8'($urandom));
    push_byte(1'b0, {dmode, 6'($urandom)});
    push_byte(1'b0, code);
    if (pmode == lrfp_pkg::MODE_ERROR) begin
      repeat ($urandom_range(0, 2)) push_byte(1'b0, 8'($urandom));
      return;
    end
    frames = (pmode == lrfp_pkg::MODE_MULTI) ? $urandom_range(1, 3) : 1;
    repeat (frames) begin
      if (pmode != lrfp_pkg::MODE_SINGLE && pmode != lrfp_pkg::MODE_MULTI) return;
      for (int i = 0; i < frame_len; i++) begin
        b = 8'($urandom);
        if (i == 1 && code == lrfp_pkg::CODE_SCAN) b[0] = ($urandom_range(0, 7) != 0);
        if ($urandom_range(0, 299) == 0) begin
          push_byte(1'b1, b);
          return;
        end
        push_byte(1'b0, b);
      end
    end
  endtask

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%s: expected %0h, got %0h", field, want, got);
    end
  endtask

  initial begin
    lrfp_pkg::result_t want;
    int hold_left;
    int stall_left;
    bit hold_done;
    hold_left = 0;
    stall_left = 0;
    hold_done = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result transaction with nothing outstanding");
        end else begin
          want = pending_results.pop_front();
          check_field("byte_out", 32'(want.byte_out), 32'(out_ch.byte_out));
          check_field("byte_index", 32'(want.byte_index), 32'(out_ch.byte_index));
          check_field("payload_valid", 32'(want.payload_valid),
                      32'(out_ch.payload_valid));
          check_field("frame_done", 32'(want.frame_done), 32'(out_ch.frame_done));
          check_field("frame_ok", 32'(want.frame_ok), 32'(out_ch.frame_ok));
          check_field("resp_kind", 32'(want.resp_kind), 32'(out_ch.resp_kind));
          check_field("delivered", 32'(want.delivered), 32'(out_ch.delivered));
          check_field("error_latched", 32'(want.error_latched),
                      32'(out_ch.error_latched));
          check_field("remaining", 32'(want.remaining), 32'(out_ch.remaining));
          check_field("conf_type_word", want.conf_type_word, out_ch.conf_type_word);
        end
      end
      if (want_hold && !hold_done) begin
        hold_left = 300;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CLOCK_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    lrfp_pkg::cfg_t c;
    int target;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.action = 1'b0;
    in_ch.rx_byte = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    regs = '{info_len: 8'd20, health_len: 8'd3, rate_len: 8'd4, scan_len: 8'd5,
             dense_len: 8'd84, measurement_count: 16'd0, buffer_mode: 1'b1};
    pmode = lrfp_pkg::MODE_DESC;
    desc_count = 0;
    frame_len = '0;
    frame_kind = lrfp_pkg::KIND_UNKNOWN;
    byte_count = '0;
    scan_left = '0;
    type_word = '0;
    scan_check = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    c = regs;
    c.measurement_count = OPENING_COUNT;
    load_regs(c);
    foreach (opening_rows[i])
      push_byte(opening_rows[i].act, opening_rows[i].rx, opening_rows[i].typed,
                opening_rows[i].kind, opening_rows[i].err);

    target = bytes_sent;
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      c.info_len = 8'($urandom_range(1, 8));
      c.health_len = 8'($urandom_range(1, 8));
      c.rate_len = 8'($urandom_range(1, 8));
      c.scan_len = 8'($urandom_range(2, 8));
      c.dense_len = 8'($urandom_range(1, 8));
      case (phase)
        0: begin
          c.measurement_count = 16'd4;
          c.buffer_mode = 1'b1;
        end
        1: begin
          c.info_len = 8'd128;
          c.health_len = 8'd0;
          c.rate_len = 8'd1;
          c.dense_len = 8'd128;
          c.measurement_count = 16'hFFFF;
          c.buffer_mode = 1'b1;
          want_hold = 1'b1;
        end
        2: begin
          c.measurement_count = 16'd0;
          c.buffer_mode = 1'b1;
        end
        default: begin
          c.measurement_count = 16'($urandom);
          c.buffer_mode = 1'b0;
        end
      endcase
      load_regs(c);
      target += RANDOM_BYTES / 4;
      while (bytes_sent < target) send_response();
    end

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
